/* rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types, register indexes, opcodes and the microcode program that
// sequences the square-and-multiply datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

   // Configuration register indexes.
   localparam int CsrIndexW = 2;
   typedef logic [CsrIndexW-1:0] csr_index_type;
   localparam csr_index_type REG_MODULUS     = 2'd0;
   localparam csr_index_type REG_PUBLIC_EXP  = 2'd1;
   localparam csr_index_type REG_PRIVATE_EXP = 2'd2;

   // Register reset values.
   localparam int ModulusReset    = 3233;
   localparam int PublicExpReset  = 17;
   localparam int PrivateExpReset = 2753;

   // Request opcodes.
   localparam logic OPC_ENCRYPT = 1'b0;
   localparam logic OPC_DECRYPT = 1'b1;

   // Step counter of the sequencer.
   typedef logic [3:0] pc_type;
   localparam pc_type PC_WAIT = 4'd0;

   // Datapath operation of one control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_START_REDUCE,
      OP_WB_BASE,
      OP_INIT_LOOP,
      OP_START_SQUARE,
      OP_WB_ACC,
      OP_START_MULT,
      OP_DEC_BIT,
      OP_EMIT,
      OP_SET_ONE,
      OP_SET_ZERO
   } op_type;

   // Jump condition of one control word; the jump is taken when it holds.
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_EXP_ZERO,
      CND_MOD_SMALL,
      CND_MUL_BUSY,
      CND_BIT_CLEAR,
      CND_BIT_NOT_LAST,
      CND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   // Microcode program. Steps that wait on the multiplier or the output
   // register jump to themselves until the condition clears.
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      case (pc)
         4'd0:    w = '{OP_LOAD,         CND_NO_REQ,       4'd0};
         4'd1:    w = '{OP_NOP,          CND_EXP_ZERO,     4'd14};
         4'd2:    w = '{OP_NOP,          CND_MOD_SMALL,    4'd15};
         4'd3:    w = '{OP_START_REDUCE, CND_NEVER,        4'd0};
         4'd4:    w = '{OP_WB_BASE,      CND_MUL_BUSY,     4'd4};
         4'd5:    w = '{OP_INIT_LOOP,    CND_NEVER,        4'd0};
         4'd6:    w = '{OP_START_SQUARE, CND_NEVER,        4'd0};
         4'd7:    w = '{OP_WB_ACC,       CND_MUL_BUSY,     4'd7};
         4'd8:    w = '{OP_NOP,          CND_BIT_CLEAR,    4'd11};
         4'd9:    w = '{OP_START_MULT,   CND_NEVER,        4'd0};
         4'd10:   w = '{OP_WB_ACC,       CND_MUL_BUSY,     4'd10};
         4'd11:   w = '{OP_DEC_BIT,      CND_BIT_NOT_LAST, 4'd6};
         4'd12:   w = '{OP_EMIT,         CND_OUT_BUSY,     4'd12};
         4'd13:   w = '{OP_NOP,          CND_ALWAYS,       4'd0};
         4'd14:   w = '{OP_SET_ONE,      CND_ALWAYS,       4'd12};
         4'd15:   w = '{OP_SET_ZERO,     CND_ALWAYS,       4'd12};
         default: w = '{OP_NOP,          CND_ALWAYS,       4'd0};
      endcase
      return w;
   endfunction

endpackage

/* rtl/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// Modular multiplier
// Interleaved shift-add multiply with reduction: one multiplier bit per
// cycle, MSB first. Operand x must be below the modulus.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] m,
   output logic             busy,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [WIDTH:0] m_ext;
   logic [WIDTH:0] dbl;
   logic [WIDTH:0] red1;
   logic [WIDTH:0] sum;
   logic [WIDTH:0] red2;

   // One step: double and reduce, then add x when the multiplier bit is set and reduce again.
   always_comb begin
      m_ext = {1'b0, m};
      dbl   = {r_ff, 1'b0};
      red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
      sum   = {1'b0, red1[WIDTH-1:0]} + (y_ff[WIDTH-1] ? {1'b0, x_ff} : '0);
      red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
   end

   // Next-state logic of the iteration.
   always_comb begin
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         r_in    = '0;
         x_in    = x;
         y_in    = y;
         cnt_in  = CW'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = red2[WIDTH-1:0];
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign busy    = busy_ff;
   assign product = r_ff;

endmodule

/* rtl/modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Raises a request value to the public (encrypt) or private (decrypt)
// exponent modulo the configured modulus.
// ----------------------------------------------------------------------------
// Usage:
// - The request channel (req_valid, req_stall, req_value, req_opcode) is
//   taken when req_valid is high and req_stall low. One request is worked on
//   at a time; req_stall is high from the cycle after acceptance until the
//   sequencer, having filled the output register, is back at its wait step.
// - The response channel (rsp_valid, rsp_stall, rsp_result) gives one
//   result per request. The output register holds it while rsp_stall is
//   high, and the next request is taken meanwhile; that request finishes its
//   work and then waits for the output register to drain.
// - Registers (modulus, public and private exponent) are written through
//   csr_valid/csr_index/csr_data; csr_ready is always high. The user must
//   make writes only while no request is in flight; the core does not enforce it.
// - Processing time is set by the bit-serial modular multiplier: a reduction
//   of the value, then one squaring per exponent bit from the top and one
//   multiply per set bit. A zero exponent or a modulus below two skips the
//   multiplier and gives one or zero respectively.
// - Synchronous reset returns the registers to their reset values, empties
//   the output register and puts the sequencer back at its wait step.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
   parameter int WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [WIDTH-1:0]                req_value,
   input  logic                            req_opcode,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [WIDTH-1:0]                rsp_result,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mexp_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [WIDTH-1:0]                csr_data
);

   localparam int BW = $clog2(WIDTH);

   logic [WIDTH-1:0]     modulus_ff, modulus_in;
   logic [WIDTH-1:0]     pub_exp_ff, pub_exp_in;
   logic [WIDTH-1:0]     priv_exp_ff, priv_exp_in;
   mexp_pkg::pc_type     pc_ff, pc_in;
   logic [WIDTH-1:0]     value_ff, value_in;
   logic [WIDTH-1:0]     expo_ff, expo_in;
   logic [WIDTH-1:0]     base_ff, base_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]     rsp_result_ff, rsp_result_in;

   mexp_pkg::uword_type  uword;
   logic                 cond_true;
   logic                 out_busy;
   logic                 mul_start;
   logic [WIDTH-1:0]     mul_x;
   logic [WIDTH-1:0]     mul_y;
   logic                 mul_busy;
   logic [WIDTH-1:0]     mul_product;

   // Shared modular multiplier.
   mexp_mulmod #(
      .WIDTH (WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (modulus_ff),
      .busy    (mul_busy),
      .product (mul_product)
   );

   // Configuration writes; indexes past the list are ignored.
   always_comb begin
      modulus_in  = modulus_ff;
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      if (csr_valid) begin
         case (csr_index)
            mexp_pkg::REG_MODULUS:     modulus_in  = csr_data;
            mexp_pkg::REG_PUBLIC_EXP:  pub_exp_in  = csr_data;
            mexp_pkg::REG_PRIVATE_EXP: priv_exp_in = csr_data;
            default: ;
         endcase
      end
   end

   // Fetch the control word of the current step.
   assign uword    = mexp_pkg::ucode_rom(pc_ff);
   assign out_busy = rsp_valid_ff && rsp_stall;

   // Jump condition.
   always_comb begin
      case (uword.cond)
         mexp_pkg::CND_NEVER:        cond_true = 1'b0;
         mexp_pkg::CND_ALWAYS:       cond_true = 1'b1;
         mexp_pkg::CND_NO_REQ:       cond_true = !req_valid;
         mexp_pkg::CND_EXP_ZERO:     cond_true = (expo_ff == '0);
         mexp_pkg::CND_MOD_SMALL:    cond_true = (modulus_ff < WIDTH'(2));
         mexp_pkg::CND_MUL_BUSY:     cond_true = mul_busy;
         mexp_pkg::CND_BIT_CLEAR:    cond_true = !expo_ff[bit_ff];
         mexp_pkg::CND_BIT_NOT_LAST: cond_true = (bit_ff != '0);
         mexp_pkg::CND_OUT_BUSY:     cond_true = out_busy;
         default:                    cond_true = 1'b0;
      endcase
      pc_in = cond_true ? uword.target : pc_ff + 1'b1;
   end

   // Datapath operations driven by the control word.
   always_comb begin
      value_in      = value_ff;
      expo_in       = expo_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      mul_start     = 1'b0;
      mul_x         = acc_ff;
      mul_y         = acc_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (uword.op)
         mexp_pkg::OP_NOP: ;
         mexp_pkg::OP_LOAD: begin
            if (req_valid) begin
               value_in = req_value;
               expo_in  = (req_opcode == mexp_pkg::OPC_DECRYPT) ? priv_exp_ff : pub_exp_ff;
            end
         end
         mexp_pkg::OP_START_REDUCE: begin
            // Value times one reduces the value below the modulus.
            mul_start = 1'b1;
            mul_x     = WIDTH'(1);
            mul_y     = value_ff;
         end
         mexp_pkg::OP_WB_BASE: begin
            if (!mul_busy) begin
               base_in = mul_product;
            end
         end
         mexp_pkg::OP_INIT_LOOP: begin
            acc_in = WIDTH'(1);
            bit_in = BW'(WIDTH - 1);
         end
         mexp_pkg::OP_START_SQUARE: begin
            mul_start = 1'b1;
         end
         mexp_pkg::OP_WB_ACC: begin
            if (!mul_busy) begin
               acc_in = mul_product;
            end
         end
         mexp_pkg::OP_START_MULT: begin
            mul_start = 1'b1;
            mul_x     = base_ff;
         end
         mexp_pkg::OP_DEC_BIT: begin
            if (bit_ff != '0) begin
               bit_in = bit_ff - 1'b1;
            end
         end
         mexp_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
            end
         end
         mexp_pkg::OP_SET_ONE:  acc_in = WIDTH'(1);
         mexp_pkg::OP_SET_ZERO: acc_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WIDTH'(mexp_pkg::ModulusReset);
         pub_exp_ff   <= WIDTH'(mexp_pkg::PublicExpReset);
         priv_exp_ff  <= WIDTH'(mexp_pkg::PrivateExpReset);
         pc_ff        <= mexp_pkg::PC_WAIT;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         pub_exp_ff   <= pub_exp_in;
         priv_exp_ff  <= priv_exp_in;
         pc_ff        <= pc_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff      <= value_in;
      expo_ff       <= expo_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign req_stall  = (pc_ff != mexp_pkg::PC_WAIT);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign csr_ready  = 1'b1;

endmodule

/* rtl/mexp_checker.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the core's ports for response handshake and sequencing rules.
// ----------------------------------------------------------------------------
module mexp_checker #(
   parameter int WIDTH = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [WIDTH-1:0]                rsp_result,
   input logic                            csr_valid,
   input logic                            csr_ready
);

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("stalled response changed");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // After an accepted request the input stalls, so no second request is taken behind it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("request taken while previous one in flight");

   // The configuration port never holds off a write.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write held off");

endmodule

bind modular_exponentiation_core mexp_checker #(
   .WIDTH (WIDTH)
) u_mexp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_result (rsp_result),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
